FILE: sv/gbuf_pkg.sv
// ----------------------------------------------------------------------------
// gbuf_pkg
// Shared types and constants for the gap buffer text editor.
// ----------------------------------------------------------------------------
`default_nettype none

package gbuf_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int LEN_W    = 7;
	localparam int CHAR_W   = 8;
	localparam int OP_W     = 3;
	localparam int STAT_W   = 2;

	localparam logic [LEN_W-1:0] CAP_PTR = LEN_W'(CAPACITY);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 3'd0,
		OP_DELETE  = 3'd1,
		OP_LEFT    = 3'd2,
		OP_RIGHT   = 3'd3,
		OP_EXTRACT = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_IGNORED = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOVE,
		S_EXT_RD,
		S_EXT_DATA
	} state_t;

endpackage

`default_nettype wire

FILE: sv/gbuf_if.sv
// ----------------------------------------------------------------------------
// gbuf_if
// Command and result channels of the gap buffer text editor.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbuf_cmd_if;
	import gbuf_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [CHAR_W-1:0] char_in;
	logic [LEN_W-1:0]  limit;

	modport source (output valid, op, char_in, limit, input ready);
	modport sink   (input valid, op, char_in, limit, output ready);
endinterface

interface gbuf_res_if;
	import gbuf_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              char_valid;
	logic              last;
	logic [LEN_W-1:0]  text_length;
	logic [STAT_W-1:0] status;

	modport source (output valid, char_out, char_valid, last, text_length, status,
		input ready);
	modport sink   (input valid, char_out, char_valid, last, text_length, status,
		output ready);
endinterface

`default_nettype wire

FILE: sv/gbuf_ram.sv
// ----------------------------------------------------------------------------
// gbuf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gbuf_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/gap_buffer_text_editor.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_editor
// Fixed-capacity gap buffer with cursor editing and text extraction.
// ----------------------------------------------------------------------------
// Insert, delete and any refused or unknown command load their result as they
// are taken; move left and move right read the store, then write back. Extract
// decodes the command, then for each emitted character reads the store and
// registers the character; an extract that emits nothing loads its result as
// it is taken. The single read port of the text store sets these steps. A
// result waits in an output register; a new command is taken only when that
// register is empty or its result transfers in the same cycle, and an extract
// holds its next store read while a character waits there. The text store
// has no reset; only the state, gap pointers and res_valid_q are cleared.
`default_nettype none

module gap_buffer_text_editor (
	input wire logic clk,
	input wire logic arst_n,
	gbuf_cmd_if.sink   cmd,
	gbuf_res_if.source res
);
	import gbuf_pkg::*;

	state_t state_q, state_d;

	logic [LEN_W-1:0] gf_q, gb_q, gf_d, gb_d;
	logic [LEN_W-1:0] i_q, n_q, n_ext;
	logic             left_q;

	logic              res_valid_q;
	logic [CHAR_W-1:0] char_out_q;
	logic              char_valid_q;
	logic              last_q;
	logic [LEN_W-1:0]  len_out_q;
	status_t           stat_q;

	logic              out_free, cmd_acc, ext_last;
	logic [LEN_W-1:0]  len_q, len_d, ext_idx;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CHAR_W-1:0] ram_wdata, ram_rdata;

	logic              ld;
	logic [CHAR_W-1:0] ld_char;
	logic              ld_cval;
	logic              ld_last;
	status_t           ld_stat;
	logic              ext_start, move_start;

	gbuf_ram #(.DEPTH(CAPACITY), .WIDTH(CHAR_W)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free = !res_valid_q || res.ready;
	assign cmd_acc  = cmd.valid && cmd.ready;
	assign len_q    = gf_q + (CAP_PTR - gb_q);
	assign len_d    = gf_d + (CAP_PTR - gb_d);
	assign n_ext    = (cmd.limit < len_q) ? cmd.limit : len_q;
	assign ext_idx  = (i_q < gf_q) ? i_q : gb_q + (i_q - gf_q);
	assign ext_last = (i_q + LEN_W'(1)) == n_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					case (cmd.op)
						OP_LEFT:    if (gf_q != '0) state_d = S_MOVE;
						OP_RIGHT:   if (gb_q != CAP_PTR) state_d = S_MOVE;
						OP_EXTRACT: if (n_ext != '0) state_d = S_EXT_RD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_MOVE:     state_d = S_IDLE;
			S_EXT_RD:   if (out_free) state_d = S_EXT_DATA;
			S_EXT_DATA: state_d = ext_last ? S_IDLE : S_EXT_RD;
			default:    state_d = S_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		cmd.ready  = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = cmd.char_in;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		gf_d       = gf_q;
		gb_d       = gb_q;
		ld         = 1'b0;
		ld_char    = '0;
		ld_cval    = 1'b0;
		ld_last    = 1'b1;
		ld_stat    = STAT_OK;
		ext_start  = 1'b0;
		move_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = out_free;
				if (cmd_acc) begin
					case (cmd.op)
						OP_INSERT: begin
							ld = 1'b1;
							if (gf_q >= gb_q) begin
								ld_stat = STAT_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = gf_q[ADDR_W-1:0];
								gf_d      = gf_q + LEN_W'(1);
							end
						end
						OP_DELETE: begin
							ld = 1'b1;
							if (gf_q == '0) ld_stat = STAT_IGNORED;
							else gf_d = gf_q - LEN_W'(1);
						end
						OP_LEFT: begin
							if (gf_q == '0) begin
								ld      = 1'b1;
								ld_stat = STAT_IGNORED;
							end else begin
								ram_re     = 1'b1;
								ram_raddr  = ADDR_W'(gf_q - LEN_W'(1));
								move_start = 1'b1;
							end
						end
						OP_RIGHT: begin
							if (gb_q == CAP_PTR) begin
								ld      = 1'b1;
								ld_stat = STAT_IGNORED;
							end else begin
								ram_re     = 1'b1;
								ram_raddr  = gb_q[ADDR_W-1:0];
								move_start = 1'b1;
							end
						end
						OP_EXTRACT: begin
							if (n_ext == '0) ld = 1'b1;
							else ext_start = 1'b1;
						end
						default: begin
							ld      = 1'b1;
							ld_stat = STAT_IGNORED;
						end
					endcase
				end
			end
			S_MOVE: begin
				ld        = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				if (left_q) begin
					ram_waddr = ADDR_W'(gb_q - LEN_W'(1));
					gf_d      = gf_q - LEN_W'(1);
					gb_d      = gb_q - LEN_W'(1);
				end else begin
					ram_waddr = gf_q[ADDR_W-1:0];
					gf_d      = gf_q + LEN_W'(1);
					gb_d      = gb_q + LEN_W'(1);
				end
			end
			S_EXT_RD: begin
				ram_re    = out_free;
				ram_raddr = ext_idx[ADDR_W-1:0];
			end
			S_EXT_DATA: begin
				ld      = 1'b1;
				ld_char = ram_rdata;
				ld_cval = 1'b1;
				ld_last = ext_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gf_q        <= '0;
			gb_q        <= CAP_PTR;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			gf_q    <= gf_d;
			gb_q    <= gb_d;
			if (ld) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			char_out_q   <= ld_char;
			char_valid_q <= ld_cval;
			last_q       <= ld_last;
			len_out_q    <= len_d;
			stat_q       <= ld_stat;
		end
		if (move_start) left_q <= (cmd.op == OP_LEFT);
		if (ext_start) begin
			n_q <= n_ext;
			i_q <= '0;
		end else if (state_q == S_EXT_DATA) begin
			i_q <= i_q + LEN_W'(1);
		end
	end

	assign res.valid       = res_valid_q;
	assign res.char_out    = char_out_q;
	assign res.char_valid  = char_valid_q;
	assign res.last        = last_q;
	assign res.text_length = len_out_q;
	assign res.status      = stat_q;

	// gap pointers stay ordered and inside the store
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		gf_q <= gb_q && gb_q <= CAP_PTR)
		else $error("gap pointers out of order");

	// commands are only taken between operations
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> state_q == S_IDLE)
		else $error("command taken while busy");

	// a fetched character always reaches the output register
	a_ext_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXT_DATA |=> res_valid_q && res.char_valid)
		else $error("extract character lost");

	// a move always ends with its result
	a_move_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE |=> res_valid_q && res.last && state_q == S_IDLE)
		else $error("move did not complete");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gap buffer text editor. A directed script covers
// the empty and full buffer, both cursor boundaries, unknown commands and the
// extract limits. A random edit stream follows, run under several patterns of
// command gaps and result back-pressure. A shadow copy of the text and gap
// pointers predicts each result the script does not fix; the bench checks all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import gbuf_pkg::*;

	localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 3'd7;
	localparam int RANDOM_ITEMS  = 260;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SCRIPT_ROWS   = 25;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              char_valid;
		logic              last;
		logic [LEN_W-1:0]  text_length;
		logic [STAT_W-1:0] status;
	} edit_result_t;

	// fixed = 1: single result typed in below, otherwise predicted
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] char_in;
		logic [LEN_W-1:0]  limit;
		logic [LEN_W-1:0]  repeats;
		logic              fixed;
		logic [STAT_W-1:0] fixed_status;
		logic [LEN_W-1:0]  fixed_length;
	} script_row_t;

	script_row_t edit_script [SCRIPT_ROWS] = '{
		'{OP_EXTRACT,    8'h00, 7'd0,  7'd1,  1'b1, STAT_OK,      7'd0},
		'{OP_EXTRACT,    8'h00, 7'd64, 7'd1,  1'b1, STAT_OK,      7'd0},
		'{OP_DELETE,     8'h00, 7'd0,  7'd1,  1'b1, STAT_IGNORED, 7'd0},
		'{OP_LEFT,       8'h00, 7'd0,  7'd1,  1'b1, STAT_IGNORED, 7'd0},
		'{OP_RIGHT,      8'h00, 7'd0,  7'd1,  1'b1, STAT_IGNORED, 7'd0},
		'{OP_UNKNOWN_LO, 8'h00, 7'd0,  7'd1,  1'b1, STAT_IGNORED, 7'd0},
		'{OP_UNKNOWN_HI, 8'hFF, 7'd64, 7'd1,  1'b1, STAT_IGNORED, 7'd0},
		'{OP_INSERT,     8'h00, 7'd0,  7'd1,  1'b0, STAT_OK,      7'd0},
		'{OP_INSERT,     8'hFF, 7'd0,  7'd1,  1'b0, STAT_OK,      7'd0},
		'{OP_INSERT,     8'hA5, 7'd0,  7'd1,  1'b0, STAT_OK,      7'd0},
		'{OP_LEFT,       8'h00, 7'd0,  7'd2,  1'b0, STAT_OK,      7'd0},
		'{OP_INSERT,     8'h5A, 7'd0,  7'd1,  1'b0, STAT_OK,      7'd0},
		'{OP_EXTRACT,    8'h00, 7'd64, 7'd1,  1'b0, STAT_OK,      7'd0},
		'{OP_EXTRACT,    8'h00, 7'd2,  7'd1,  1'b0, STAT_OK,      7'd0},
		'{OP_RIGHT,      8'h00, 7'd0,  7'd3,  1'b0, STAT_OK,      7'd0},
		'{OP_DELETE,     8'h00, 7'd0,  7'd1,  1'b0, STAT_OK,      7'd0},
		'{OP_INSERT,     8'h30, 7'd0,  7'd61, 1'b0, STAT_OK,      7'd0},
		'{OP_INSERT,     8'h77, 7'd0,  7'd1,  1'b1, STAT_FULL,    7'd64},
		'{OP_EXTRACT,    8'h00, 7'd64, 7'd1,  1'b0, STAT_OK,      7'd0},
		'{OP_LEFT,       8'h00, 7'd0,  7'd10, 1'b0, STAT_OK,      7'd0},
		'{OP_INSERT,     8'h88, 7'd0,  7'd1,  1'b1, STAT_FULL,    7'd64},
		'{OP_EXTRACT,    8'h00, 7'd28, 7'd1,  1'b0, STAT_OK,      7'd0},
		'{OP_LEFT,       8'h00, 7'd0,  7'd55, 1'b0, STAT_OK,      7'd0},
		'{OP_EXTRACT,    8'h00, 7'd33, 7'd1,  1'b0, STAT_OK,      7'd0},
		'{OP_RIGHT,      8'h00, 7'd0,  7'd12, 1'b0, STAT_OK,      7'd0}
	};

	int idle_plan  [4] = '{0, 48, 0, 35};
	int stall_plan [4] = '{0, 0, 48, 35};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gbuf_cmd_if cmd_ch ();
	gbuf_res_if res_ch ();

	gap_buffer_text_editor i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// shadow of the editor
	logic [CHAR_W-1:0] shadow_text [CAPACITY];
	int                shadow_front = 0;
	int                shadow_back  = CAPACITY;

	edit_result_t due_results [$];
	int           errors = 0;
	int           cycles = 0;
	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [LEN_W-1:0] held_chars();
		return LEN_W'(shadow_front + CAPACITY - shadow_back);
	endfunction

	task automatic predict_edit(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
		input logic [LEN_W-1:0] lim, input bit record);
		int                n;
		bit                single;
		logic [STAT_W-1:0] st;
		edit_result_t      r;
		st = STAT_OK;
		single = 1'b1;
		case (op)
			OP_INSERT: begin
				if (shadow_front >= shadow_back) begin
					st = STAT_FULL;
				end else begin
					shadow_text[shadow_front] = ch;
					shadow_front++;
				end
			end
			OP_DELETE: begin
				if (shadow_front == 0) st = STAT_IGNORED;
				else shadow_front--;
			end
			OP_LEFT: begin
				if (shadow_front == 0) begin
					st = STAT_IGNORED;
				end else begin
					shadow_front--;
					shadow_back--;
					shadow_text[shadow_back] = shadow_text[shadow_front];
				end
			end
			OP_RIGHT: begin
				if (shadow_back >= CAPACITY) begin
					st = STAT_IGNORED;
				end else begin
					shadow_text[shadow_front] = shadow_text[shadow_back];
					shadow_front++;
					shadow_back++;
				end
			end
			OP_EXTRACT: begin
				n = (int'(lim) < int'(held_chars())) ? int'(lim) : int'(held_chars());
				if (n > 0) begin
					single = 1'b0;
					for (int i = 0; i < n; i++) begin
						r.char_out    = (i < shadow_front) ? shadow_text[i] :
							shadow_text[shadow_back + i - shadow_front];
						r.char_valid  = 1'b1;
						r.last        = (i == n - 1);
						r.text_length = held_chars();
						r.status      = STAT_OK;
						if (record) due_results.push_back(r);
					end
				end
			end
			default: st = STAT_IGNORED;
		endcase
		if (single && record) begin
			r = '{char_out: '0, char_valid: 1'b0, last: 1'b1,
				text_length: held_chars(), status: st};
			due_results.push_back(r);
		end
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic issue(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
		input logic [LEN_W-1:0] lim, input bit fixed, input logic [STAT_W-1:0] fixed_status,
		input logic [LEN_W-1:0] fixed_length);
		edit_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.op      <= op;
		cmd_ch.char_in <= ch;
		cmd_ch.limit   <= lim;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		predict_edit(op, ch, lim, !fixed);
		if (fixed) begin
			r = '{char_out: '0, char_valid: 1'b0, last: 1'b1,
				text_length: fixed_length, status: fixed_status};
			due_results.push_back(r);
		end
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (due_results.size() != 0);
	endtask

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		edit_result_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{char_out: res_ch.char_out, char_valid: res_ch.char_valid,
				last: res_ch.last, text_length: res_ch.text_length, status: res_ch.status};
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result: char %h valid %b last %b len %0d status %0d",
					$time, got.char_out, got.char_valid, got.last, got.text_length, got.status);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					$display("%0t: expected char %h valid %b last %b len %0d status %0d",
						$time, want.char_out, want.char_valid, want.last, want.text_length,
						want.status);
					$display("%0t:      got char %h valid %b last %b len %0d status %0d",
						$time, got.char_out, got.char_valid, got.last, got.text_length,
						got.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[gap_buffer_text_editor] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		script_row_t       row;
		int                roll;
		bit                filling;
		logic [OP_W-1:0]   op;
		logic [LEN_W-1:0]  lim;
		logic [CHAR_W-1:0] ch;
		int                lo, hi;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.op      <= OP_INSERT;
		cmd_ch.char_in <= '0;
		cmd_ch.limit   <= '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < SCRIPT_ROWS; r++) begin
			row = edit_script[r];
			for (int k = 0; k < row.repeats; k++)
				issue(row.op, row.char_in + CHAR_W'(k), row.limit, row.fixed,
					row.fixed_status, row.fixed_length);
		end
		hold_until_drained();

		filling = 1'b0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_plan[ph];
			recv_stall_pct = stall_plan[ph];
			for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
				if (held_chars() == CAPACITY) filling = 1'b0;
				else if (held_chars() == 0) filling = 1'b1;
				else if ($urandom_range(0, 29) == 0) filling = !filling;
				roll = $urandom_range(0, 99);
				if (roll < (filling ? 45 : 12)) op = OP_INSERT;
				else if (roll < 55) op = OP_DELETE;
				else if (roll < 70) op = OP_LEFT;
				else if (roll < 85) op = OP_RIGHT;
				else if (roll < 97) op = OP_EXTRACT;
				else op = OP_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
				if ($urandom_range(0, 3) == 0) begin
					lo = (held_chars() > 0) ? held_chars() - 1 : 0;
					hi = (held_chars() < CAPACITY) ? held_chars() + 1 : CAPACITY;
					lim = LEN_W'($urandom_range(lo, hi));
				end else begin
					lim = LEN_W'($urandom_range(0, CAPACITY));
				end
				ch = CHAR_W'($urandom_range(0, 255));
				issue(op, ch, lim, 1'b0, STAT_OK, '0);
			end
			hold_until_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, due_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("[gap_buffer_text_editor] OK");
		end else begin
			$display("[gap_buffer_text_editor] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
